/* hdl/cli_pkg.sv */
// Types and codes shared by the circular list insert/delete block.
package cli_pkg;

  localparam int DATA_W = 32;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_FRONT  = 2'd0;
  localparam req_t REQ_BACK   = 2'd1;
  localparam req_t REQ_DELETE = 2'd2;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_FULL     = 2'd1;
  localparam status_t STAT_EMPTY    = 2'd2;
  localparam status_t STAT_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH0,
    S_SRCH,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

/* hdl/circular_list_insert_delete_top.sv */
// Circular list insert/delete: ordered list of signed words in a ring RAM,
// with front index and entry count. One request is taken at a time. An insert
// (front or back), a delete of an empty list and an unused request code go
// straight to S_RESP, which registers their result word once the output
// register is free. A delete walks the list from the front, one RAM read a
// cycle, then moves each later entry down one place, one read and one write a
// cycle. The single read port of the ring RAM and the shared slot adder set
// this pace. in_stall stays high from acceptance until the result word is
// registered; a registered result may wait on out_stall while the next request
// is accepted. The RAM is not cleared; only live entries are read.
module circular_list_insert_delete_top #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cli_pkg::req_t                    in_req_type,
  input  logic signed [cli_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cli_pkg::status_t                 out_status,
  output logic [$clog2(CAPACITY+1)-1:0]    out_entry_count
);

  import cli_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = IW + 1;

  state_t              state_r, state_nxt;
  logic [IW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [IW-1:0]       wslot_r, wslot_nxt;
  logic [IW-1:0]       last_slot_r, last_slot_nxt;
  logic [DATA_W-1:0]   value_r, value_nxt;
  status_t             status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [CW-1:0]       out_count_r, out_count_nxt;

  logic [CW-1:0]       pos_sel;
  logic [SW-1:0]       slot_sum;
  logic [IW-1:0]       slot;
  logic [IW-1:0]       front_dec;
  logic                full;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   rd_data;

  cli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (rd_data)
  );

  assign pos_sel   = (state_r == S_IDLE) ? count_r : scan_r;
  assign slot_sum  = SW'(front_r) + SW'(pos_sel);
  assign slot      = (slot_sum >= SW'(CAPACITY)) ? IW'(slot_sum - SW'(CAPACITY))
                                                 : IW'(slot_sum);
  assign front_dec = (front_r == '0) ? IW'(CAPACITY - 1) : front_r - IW'(1);
  assign full      = (count_r >= CW'(CAPACITY));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    wslot_r      <= wslot_nxt;
    last_slot_r  <= last_slot_nxt;
    value_r      <= value_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    wslot_nxt      = wslot_r;
    last_slot_nxt  = last_slot_r;
    value_nxt      = value_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = slot;
    ram_wdata      = value_r;
    in_stall       = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt  = in_value;
          status_nxt = STAT_OK;
          state_nxt  = S_RESP;
          unique case (in_req_type)
            REQ_FRONT: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                ram_wdata = in_value;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_BACK: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot;
                ram_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_DELETE: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                scan_nxt  = '0;
                state_nxt = S_SRCH0;
              end
            end
            default: begin
              status_nxt = STAT_OK;
            end
          endcase
        end
      end
      S_SRCH0: begin
        last_slot_nxt = slot;
        scan_nxt      = scan_r + CW'(1);
        state_nxt     = S_SRCH;
      end
      S_SRCH: begin
        if (rd_data == value_r) begin
          if (scan_r < count_r) begin
            wslot_nxt     = last_slot_r;
            last_slot_nxt = slot;
            scan_nxt      = scan_r + CW'(1);
            state_nxt     = S_SHIFT;
          end else begin
            count_nxt  = count_r - CW'(1);
            status_nxt = STAT_OK;
            state_nxt  = S_RESP;
          end
        end else if (scan_r == count_r) begin
          status_nxt = STAT_NOTFOUND;
          state_nxt  = S_RESP;
        end else begin
          last_slot_nxt = slot;
          scan_nxt      = scan_r + CW'(1);
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wslot_r;
        ram_wdata = rd_data;
        if (scan_r < count_r) begin
          wslot_nxt     = last_slot_r;
          last_slot_nxt = slot;
          scan_nxt      = scan_r + CW'(1);
        end else begin
          count_nxt  = count_r - CW'(1);
          status_nxt = STAT_OK;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) || (state_r == S_SHIFT) |-> scan_r <= count_r)
    else $error("scan position beyond list");

  a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result word raised outside response state");
`endif

endmodule

/* hdl/cli_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module cli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/circular_list_insert_delete_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for circular_list_insert_delete_top: directed table, then random checked requests.
module circular_list_insert_delete_top_tb;
  import cli_pkg::*;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RANDOM_ITEMS = 1025;
  localparam int QUIET_ITEMS = 100;
  localparam int POOL_SIZE = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam req_t REQ_UNUSED = 2'd3;

  typedef struct packed {
    req_t req;
    logic [DATA_W-1:0] value;
    logic known;
    status_t status;
    logic [CNT_W-1:0] count;
  } dir_row_t;

  typedef struct packed {
    status_t status;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req_type;
  logic signed [DATA_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  status_t out_status;
  logic [CNT_W-1:0] out_entry_count;

  logic [DATA_W-1:0] ring [CAPACITY];
  int ring_front;
  int ring_count;
  list_result_t pending_results [$];
  logic [DATA_W-1:0] value_pool [POOL_SIZE];
  bit idle_on;
  int stall_left;
  int errors = 0;
  int cycle_count = 0;

  dir_row_t dir_rows [25] = '{
    '{REQ_DELETE, 32'h0000_0000, 1'b1, STAT_EMPTY, 5'd0},
    '{REQ_UNUSED, 32'h0000_0000, 1'b1, STAT_OK, 5'd0},
    '{REQ_FRONT, 32'h8000_0000, 1'b1, STAT_OK, 5'd1},
    '{REQ_BACK, 32'h7FFF_FFFF, 1'b1, STAT_OK, 5'd2},
    '{REQ_DELETE, 32'h0000_0000, 1'b1, STAT_NOTFOUND, 5'd2},
    '{REQ_FRONT, 32'hFFFF_FFFF, 1'b1, STAT_OK, 5'd3},
    '{REQ_BACK, 32'h0000_0000, 1'b1, STAT_OK, 5'd4},
    '{REQ_FRONT, 32'h5555_5555, 1'b0, STAT_OK, 5'd0},
    '{REQ_BACK, 32'hAAAA_AAAA, 1'b0, STAT_OK, 5'd0},
    '{REQ_FRONT, 32'h5555_5555, 1'b0, STAT_OK, 5'd0},
    '{REQ_BACK, 32'hAAAA_AAAA, 1'b0, STAT_OK, 5'd0},
    '{REQ_FRONT, 32'h0000_0001, 1'b0, STAT_OK, 5'd0},
    '{REQ_BACK, 32'h8000_0000, 1'b0, STAT_OK, 5'd0},
    '{REQ_FRONT, 32'h5555_5555, 1'b0, STAT_OK, 5'd0},
    '{REQ_BACK, 32'hFFFF_FFFE, 1'b0, STAT_OK, 5'd0},
    '{REQ_FRONT, 32'h7FFF_FFFF, 1'b0, STAT_OK, 5'd0},
    '{REQ_BACK, 32'h5555_5555, 1'b0, STAT_OK, 5'd0},
    '{REQ_FRONT, 32'h1234_5678, 1'b0, STAT_OK, 5'd0},
    '{REQ_BACK, 32'hAAAA_AAAA, 1'b0, STAT_OK, 5'd0},
    '{REQ_FRONT, 32'hDEAD_BEEF, 1'b1, STAT_FULL, 5'd16},
    '{REQ_BACK, 32'h0000_0000, 1'b1, STAT_FULL, 5'd16},
    '{REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, STAT_OK, 5'd16},
    '{REQ_DELETE, 32'h5555_5555, 1'b0, STAT_OK, 5'd0},
    '{REQ_DELETE, 32'hAAAA_AAAA, 1'b0, STAT_OK, 5'd0},
    '{REQ_DELETE, 32'h0F0F_0F0F, 1'b0, STAT_OK, 5'd0}
  };

  circular_list_insert_delete_top #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic apply_request(input req_t req, input logic [DATA_W-1:0] val,
                               output status_t st, output logic [CNT_W-1:0] cnt);
    int pos;
    int k;
    st = STAT_OK;
    case (req)
      REQ_FRONT: begin
        if (ring_count >= CAPACITY) begin
          st = STAT_FULL;
        end else begin
          ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
          ring[ring_front] = val;
          ring_count++;
        end
      end
      REQ_BACK: begin
        if (ring_count >= CAPACITY) begin
          st = STAT_FULL;
        end else begin
          ring[(ring_front + ring_count) % CAPACITY] = val;
          ring_count++;
        end
      end
      REQ_DELETE: begin
        if (ring_count == 0) begin
          st = STAT_EMPTY;
        end else begin
          pos = ring_count;
          for (k = ring_count - 1; k >= 0; k--) begin
            if (ring[(ring_front + k) % CAPACITY] == val) pos = k;
          end
          if (pos == ring_count) begin
            st = STAT_NOTFOUND;
          end else begin
            for (k = pos; k + 1 < ring_count; k++) begin
              ring[(ring_front + k) % CAPACITY] = ring[(ring_front + k + 1) % CAPACITY];
            end
            ring_count--;
          end
        end
      end
      default: ;
    endcase
    cnt = ring_count[CNT_W-1:0];
  endtask

  task automatic send_request(input req_t req, input logic [DATA_W-1:0] val, input logic known,
                              input status_t known_status, input logic [CNT_W-1:0] known_count);
    status_t st;
    logic [CNT_W-1:0] cnt;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(req, val, st, cnt);
    if (known) begin
      pending_results.push_back(list_result_t'{known_status, known_count});
    end else begin
      pending_results.push_back(list_result_t'{st, cnt});
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    stall_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: status %0d, entry_count %0d",
                 $time, out_status, out_entry_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
          errors++;
        end
        if (out_entry_count !== want.count) begin
          $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                   $time, want.count, out_entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    req_t req;
    logic [DATA_W-1:0] val;
    int n;
    int pick;
    bit filling;
    ring_front = 0;
    ring_count = 0;
    idle_on = 1'b1;
    filling = 1'b1;
    in_valid <= 1'b0;
    in_req_type <= REQ_FRONT;
    in_value <= '0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].value, dir_rows[i].known,
                   dir_rows[i].status, dir_rows[i].count);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        foreach (value_pool[j]) value_pool[j] = $urandom;
        case ((n / 64) % 4)
          0: value_pool[0] = 32'h8000_0000;
          1: value_pool[0] = 32'h7FFF_FFFF;
          2: value_pool[0] = 32'h0000_0000;
          default: value_pool[0] = 32'hFFFF_FFFF;
        endcase
      end
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      if (ring_count == CAPACITY && $urandom_range(0, 7) == 0) begin
        filling = 1'b0;
      end else if (ring_count == 0 && $urandom_range(0, 2) == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        filling = !filling;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        req = REQ_UNUSED;
      end else if (pick < (filling ? 78 : 33)) begin
        req = ($urandom_range(0, 1) != 0) ? REQ_BACK : REQ_FRONT;
      end else begin
        req = REQ_DELETE;
      end
      if (req == REQ_DELETE && ring_count > 0 && $urandom_range(0, 9) < 7) begin
        val = ring[(ring_front + $urandom_range(0, ring_count - 1)) % CAPACITY];
      end else if ($urandom_range(0, 9) < 6) begin
        val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        val = $urandom;
      end
      send_request(req, val, 1'b0, STAT_OK, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
